FILE: rtl/ffsba_pkg.sv
// Shared constants, codes and types for the first-fit slot bitmap allocator.
// No dependencies; every other file of the block refers to this package.
package ffsba_pkg;

  localparam int MAX_SLOTS_DEF = 4096;
  localparam int WORD_BITS     = 64;
  localparam int BIT_W         = 6;
  localparam int MAP_AW_DEF    = $clog2((MAX_SLOTS_DEF + WORD_BITS - 1) / WORD_BITS);

  localparam int ACT_W      = 2;
  localparam int STAT_W     = 2;
  localparam int GROUP_W    = 16;
  localparam int CNT_W      = 13;
  localparam int NUM_W      = 28;
  localparam int SIDX_W     = 12;
  localparam int PROD_W     = GROUP_W + CNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = NUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MARK  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE      = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID      = 2'd2;
  localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MOD,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

endpackage

FILE: rtl/first_fit_slot_bitmap_allocator_core.sv
// Top level of the first-fit slot bitmap allocator: control sequencer, config
// registers, allocated count. Uses ffsba_pkg, ffsba_map_ram, ffsba_rem_unit.
//
//   channel   ports                                       transfer when
//   command   start, action, global_number, slot_index    start && !busy
//   result    done, status, allocated_number, free_count  done (one cycle)
//   config    cfg_valid, cfg_index, cfg_data, cfg_ready   cfg_valid && cfg_ready
//
// Steps from command to result: allocate scans map words, one 64-bit word per
// cycle through the map read port, up to MAP_WORDS, and marks the first free
// slot; free runs the 28-step remainder unit plus a read-modify-write; mark-used
// does a read-modify-write; a command rejected up front is answered from idle.
// A new command is taken in the cycle its predecessor's result is shown. After
// reset a clearing pass writes all 2**WORD_AW map rows (64 by default) with
// busy high; config writes are taken at all times. The result side cannot stall.
module first_fit_slot_bitmap_allocator_core #(
  parameter int MAX_SLOTS = ffsba_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ffsba_pkg::ACT_W-1:0]      action,
  input  logic [ffsba_pkg::NUM_W-1:0]      global_number,
  input  logic [ffsba_pkg::SIDX_W-1:0]     slot_index,
  output logic                             done,
  output logic [ffsba_pkg::STAT_W-1:0]     status,
  output logic [ffsba_pkg::NUM_W-1:0]      allocated_number,
  output logic [ffsba_pkg::CNT_W-1:0]      free_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ffsba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffsba_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MAP_WORDS = (MAX_SLOTS + ffsba_pkg::WORD_BITS - 1) / ffsba_pkg::WORD_BITS;
  localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int RAM_DEPTH = 2 ** WORD_AW;
  localparam int SLOT_W    = WORD_AW + ffsba_pkg::BIT_W;
  localparam int TOT_W     = $clog2(MAX_SLOTS + 1);
  localparam int WB        = ffsba_pkg::WORD_BITS;
  localparam int BW        = ffsba_pkg::BIT_W;
  localparam int CW        = ffsba_pkg::CNT_W;

  localparam logic [WORD_AW-1:0] LAST_ROW = WORD_AW'(RAM_DEPTH - 1);

  function automatic logic [BW-1:0] low_index(input logic [WB-1:0] v);
    logic [WB-1:0] iso;
    logic [BW-1:0] idx;
    iso = v & (~v + WB'(1));
    idx = '0;
    for (int i = 0; i < WB; i++) begin
      if (iso[i]) begin
        idx = idx | BW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [CW-1:0] free_of(input logic [CW-1:0] n,
                                            input logic [TOT_W-1:0] t);
    logic [31:0] diff;
    diff = (32'(n) > 32'(t)) ? (32'(n) - 32'(t)) : 32'd0;
    return diff[CW-1:0];
  endfunction

  // Configuration registers.
  logic [ffsba_pkg::GROUP_W-1:0] group_index;
  logic [CW-1:0]                 slot_count;
  logic [CW-1:0]                 reserved_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_index    <= '0;
      slot_count     <= CW'(4096);
      reserved_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ffsba_pkg::CFG_GROUP:    group_index    <= cfg_data;
        ffsba_pkg::CFG_SLOTS:    slot_count     <= cfg_data[CW-1:0];
        ffsba_pkg::CFG_RESERVED: reserved_count <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  ffsba_pkg::state_t state, state_next;
  logic [WORD_AW-1:0]           clr_addr, clr_addr_next;
  logic [WORD_AW-1:0]           scan_ptr, scan_ptr_next;
  logic [WORD_AW-1:0]           data_addr, data_addr_next;
  logic [WORD_AW-1:0]           first_word, first_word_next;
  logic [WORD_AW-1:0]           last_word, last_word_next;
  logic [BW-1:0]                lo_sh, lo_sh_next;
  logic [BW-1:0]                hi_b, hi_b_next;
  logic [SLOT_W-1:0]            target, target_next;
  logic [ffsba_pkg::ACT_W-1:0]  op, op_next;
  logic [ffsba_pkg::PROD_W-1:0] prod, prod_next;
  logic [TOT_W-1:0]             total, total_next;
  logic                         done_next;
  logic [ffsba_pkg::STAT_W-1:0] status_next;
  logic [ffsba_pkg::NUM_W-1:0]  number_next;
  logic [CW-1:0]                free_next;

  // Map port and remainder unit connections.
  logic               rd_en;
  logic [WORD_AW-1:0] rd_addr;
  logic [WB-1:0]      rd_data;
  logic               wr_en;
  logic [WORD_AW-1:0] wr_addr;
  logic [WB-1:0]      wr_data;
  ffsba_pkg::mod_req_t mod_req;
  ffsba_pkg::mod_rsp_t mod_rsp;

  ffsba_map_ram #(
    .ADDR_W (WORD_AW)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ffsba_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // Derived values.
  logic [CW-1:0]     n_eff;
  logic [CW-1:0]     n_m1;
  logic [CW-1:0]     start_cnt;
  logic [SLOT_W-1:0] start_slot;
  logic [SLOT_W-1:0] last_slot;
  logic [SLOT_W-1:0] mark_slot;
  logic [SLOT_W-1:0] mod_slot;
  logic [WB-1:0]     lo_mask;
  logic [WB-1:0]     hi_mask;
  logic [WB-1:0]     cand;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              cur_bit;

  assign n_eff      = (32'(slot_count) > MAX_SLOTS) ? CW'(MAX_SLOTS) : slot_count;
  assign n_m1       = n_eff - CW'(1);
  assign start_cnt  = (group_index == '0) ? reserved_count : '0;
  assign start_slot = SLOT_W'(start_cnt);
  assign last_slot  = SLOT_W'(n_m1);
  assign mark_slot  = SLOT_W'(slot_index);
  assign mod_slot   = SLOT_W'(mod_rsp.rem);

  // Bits below the start slot in the first word and at or above the slot
  // count in the last word are excluded from the search.
  assign lo_mask  = (data_addr == first_word) ? ({WB{1'b1}} << lo_sh) : {WB{1'b1}};
  assign hi_mask  = (data_addr == last_word) ? ({WB{1'b1}} >> (BW'(WB - 1) - hi_b))
                                             : {WB{1'b1}};
  assign cand     = ~rd_data & lo_mask & hi_mask;
  assign hit      = |cand;
  assign hit_slot = {data_addr, low_index(cand)};
  assign cur_bit  = rd_data[target[BW-1:0]];

  assign busy = (state != ffsba_pkg::S_IDLE);

  logic                         fin;
  logic [ffsba_pkg::STAT_W-1:0] fin_status;
  logic [ffsba_pkg::NUM_W-1:0]  fin_number;

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    scan_ptr_next   = scan_ptr;
    data_addr_next  = data_addr;
    first_word_next = first_word;
    last_word_next  = last_word;
    lo_sh_next      = lo_sh;
    hi_b_next       = hi_b;
    target_next     = target;
    op_next         = op;
    prod_next       = prod;
    total_next      = total;
    done_next       = 1'b0;
    status_next     = status;
    number_next     = allocated_number;
    free_next       = free_count;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    mod_req         = '0;
    fin             = 1'b0;
    fin_status      = ffsba_pkg::ST_OK;
    fin_number      = '0;

    case (state)
      ffsba_pkg::S_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_ROW) begin
          state_next = ffsba_pkg::S_IDLE;
        end
      end
      ffsba_pkg::S_IDLE: begin
        if (start) begin
          op_next = action;
          case (action)
            ffsba_pkg::ACT_ALLOC: begin
              if (free_of(n_eff, total) == '0 || start_cnt >= n_eff) begin
                fin        = 1'b1;
                fin_status = ffsba_pkg::ST_NO_FREE;
              end else begin
                rd_en           = 1'b1;
                rd_addr         = start_slot[SLOT_W-1:BW];
                data_addr_next  = start_slot[SLOT_W-1:BW];
                scan_ptr_next   = start_slot[SLOT_W-1:BW] + 1'b1;
                first_word_next = start_slot[SLOT_W-1:BW];
                last_word_next  = last_slot[SLOT_W-1:BW];
                lo_sh_next      = start_slot[BW-1:0];
                hi_b_next       = last_slot[BW-1:0];
                prod_next       = ffsba_pkg::PROD_W'(group_index) * ffsba_pkg::PROD_W'(n_eff);
                state_next      = ffsba_pkg::S_SCAN;
              end
            end
            ffsba_pkg::ACT_FREE: begin
              if (n_eff == '0) begin
                fin        = 1'b1;
                fin_status = ffsba_pkg::ST_INVALID;
              end else begin
                mod_req.go       = 1'b1;
                mod_req.dividend = global_number;
                mod_req.divisor  = n_eff;
                state_next       = ffsba_pkg::S_MOD;
              end
            end
            ffsba_pkg::ACT_MARK: begin
              if ({1'b0, slot_index} >= n_eff) begin
                fin        = 1'b1;
                fin_status = ffsba_pkg::ST_INVALID;
              end else begin
                target_next = mark_slot;
                rd_en       = 1'b1;
                rd_addr     = mark_slot[SLOT_W-1:BW];
                state_next  = ffsba_pkg::S_APPLY;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = ffsba_pkg::ST_INVALID;
            end
          endcase
        end
      end
      ffsba_pkg::S_SCAN: begin
        if (hit) begin
          wr_en      = 1'b1;
          wr_addr    = data_addr;
          wr_data    = rd_data | (WB'(1) << hit_slot[BW-1:0]);
          total_next = total + 1'b1;
          fin        = 1'b1;
          fin_number = ffsba_pkg::NUM_W'(prod + ffsba_pkg::PROD_W'(hit_slot));
          state_next = ffsba_pkg::S_IDLE;
        end else if (data_addr == last_word) begin
          fin        = 1'b1;
          fin_status = ffsba_pkg::ST_NO_FREE;
          state_next = ffsba_pkg::S_IDLE;
        end else begin
          // Fetch the next word now; its data is here in the following cycle.
          rd_en          = 1'b1;
          rd_addr        = scan_ptr;
          data_addr_next = scan_ptr;
          scan_ptr_next  = scan_ptr + 1'b1;
        end
      end
      ffsba_pkg::S_MOD: begin
        if (mod_rsp.done) begin
          target_next = mod_slot;
          rd_en       = 1'b1;
          rd_addr     = mod_slot[SLOT_W-1:BW];
          state_next  = ffsba_pkg::S_APPLY;
        end
      end
      ffsba_pkg::S_APPLY: begin
        fin        = 1'b1;
        state_next = ffsba_pkg::S_IDLE;
        if (op == ffsba_pkg::ACT_FREE) begin
          if (!cur_bit) begin
            fin_status = ffsba_pkg::ST_ALREADY_FREE;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = target[SLOT_W-1:BW];
            wr_data    = rd_data & ~(WB'(1) << target[BW-1:0]);
            total_next = total - 1'b1;
          end
        end else if (!cur_bit) begin
          wr_en      = 1'b1;
          wr_addr    = target[SLOT_W-1:BW];
          wr_data    = rd_data | (WB'(1) << target[BW-1:0]);
          total_next = total + 1'b1;
        end
      end
      default: begin
        state_next = ffsba_pkg::S_IDLE;
      end
    endcase

    if (fin) begin
      done_next   = 1'b1;
      status_next = fin_status;
      number_next = fin_number;
      free_next   = free_of(n_eff, total_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffsba_pkg::S_CLEAR;
      clr_addr <= '0;
      total    <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      total    <= total_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr         <= scan_ptr_next;
    data_addr        <= data_addr_next;
    first_word       <= first_word_next;
    last_word        <= last_word_next;
    lo_sh            <= lo_sh_next;
    hi_b             <= hi_b_next;
    target           <= target_next;
    op               <= op_next;
    prod             <= prod_next;
    status           <= status_next;
    allocated_number <= number_next;
    free_count       <= free_next;
  end

  // A command is either still at work or answered in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither busy nor answered");

  // The remainder unit finishes only while the sequencer waits for it.
  a_rem_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> (state == ffsba_pkg::S_MOD))
    else $error("remainder result outside of the free sequence");

  // A failed command never reports an allocated number.
  a_number_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && status != ffsba_pkg::ST_OK) |-> (allocated_number == '0))
    else $error("nonzero number with failing status");

  // The allocated count can never exceed the map size.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(total) <= MAX_SLOTS))
    else $error("allocated count beyond map size");

endmodule

FILE: rtl/ffsba_map_ram.sv
// Allocation map storage: one 64-bit word per row, one write and one read port.
// Read data is registered. Uses ffsba_pkg.
module ffsba_map_ram #(
  parameter int ADDR_W = ffsba_pkg::MAP_AW_DEF
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  output logic [ffsba_pkg::WORD_BITS-1:0] rd_data,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [ffsba_pkg::WORD_BITS-1:0] wr_data
);

  logic [ffsba_pkg::WORD_BITS-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/ffsba_rem_unit.sv
// Restoring remainder unit: global number modulo slot count, one quotient bit
// per cycle. Uses ffsba_pkg for widths and request types.
module ffsba_rem_unit (
  input  logic                clk,
  input  logic                rst,
  input  ffsba_pkg::mod_req_t req,
  output ffsba_pkg::mod_rsp_t rsp
);

  localparam logic [ffsba_pkg::DIV_CNT_W-1:0] LAST_STEP =
    ffsba_pkg::DIV_CNT_W'(ffsba_pkg::DIV_STEPS - 1);

  logic                           active;
  logic                           done;
  logic [ffsba_pkg::DIV_CNT_W-1:0] cnt;
  logic [ffsba_pkg::NUM_W-1:0]    shift;
  logic [ffsba_pkg::CNT_W-1:0]    rem;
  logic [ffsba_pkg::CNT_W-1:0]    divisor;
  logic [ffsba_pkg::CNT_W:0]      trial;
  logic [ffsba_pkg::CNT_W-1:0]    rem_next;

  // The partial remainder stays below the divisor, so one extra bit suffices.
  always_comb begin
    trial = {rem, shift[ffsba_pkg::NUM_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = ffsba_pkg::CNT_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[ffsba_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      shift   <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (active) begin
      shift <= {shift[ffsba_pkg::NUM_W-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule
